@@ hdl/dtc_pkg.sv @@
// Shared types, codes and helpers for the divider/timer counter block.
`timescale 1ns / 1ps

package dtc_pkg;

    localparam int SYS_W   = 16;
    localparam int TIM_W   = 8;
    localparam int CYC_W   = 8;
    localparam int CTRL_W  = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;
    localparam int CHUNK_W = 3;
    localparam logic [CHUNK_W-1:0] CHUNK_MAX = 3'd4;

    localparam logic [1:0] MODE_ADVANCE = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CONTROL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELOAD_VALUE  = 8'd1;

    localparam int CTRL_ENABLE_BIT = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch a new item
        logic step;   // advance one chunk
        logic emit;   // move the result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic remain_zero;
        logic out_free;
    } t_sts;

    // tap bit position of the system counter for a select code
    function automatic logic [3:0] tap_index(input logic [1:0] sel);
        logic [3:0] idx;
        case (sel)
            2'd0:    idx = 4'd9;
            2'd1:    idx = 4'd3;
            2'd2:    idx = 4'd5;
            default: idx = 4'd7;
        endcase
        return idx;
    endfunction

endpackage

@@ hdl/dtc_ctrl.sv @@
// Controller state machine: sequences item load, chunk steps and result hand-off.
`timescale 1ns / 1ps

module dtc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dtc_pkg::t_sts i_sts,
    output dtc_pkg::t_cmd o_cmd
);

    dtc_pkg::t_state r_state;
    dtc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dtc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = dtc_pkg::ST_RUN;
            end
            dtc_pkg::ST_RUN: begin
                if (i_sts.remain_zero && i_sts.out_free) n_state = dtc_pkg::ST_IDLE;
            end
            default: n_state = dtc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            dtc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            dtc_pkg::ST_RUN: begin
                // wait here with the finished result while the output is still occupied
                o_cmd.step = !i_sts.remain_zero;
                o_cmd.emit = i_sts.remain_zero && i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/dtc_datapath.sv @@
// Datapath: system and timer counters, config registers and the output register.
`timescale 1ns / 1ps

module dtc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dtc_pkg::t_cmd                     i_cmd,
    output dtc_pkg::t_sts                     o_sts,
    input  logic [1:0]                        i_mode,
    input  logic [dtc_pkg::CYC_W-1:0]         i_cycles,
    input  logic [dtc_pkg::TIM_W-1:0]         i_write_value,
    input  logic                              i_cfg_we,
    input  logic [dtc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [dtc_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [dtc_pkg::TIM_W-1:0]         o_divider,
    output logic [dtc_pkg::TIM_W-1:0]         o_counter,
    output logic                              o_irq
);

    logic [dtc_pkg::SYS_W-1:0]   r_sys;
    logic [dtc_pkg::TIM_W-1:0]   r_tim;
    logic [dtc_pkg::CYC_W-1:0]   r_remain;
    logic                        r_irq;
    logic [dtc_pkg::CTRL_W-1:0]  r_ctrl;
    logic [dtc_pkg::TIM_W-1:0]   r_reload;
    logic                        r_out_valid;
    logic [dtc_pkg::TIM_W-1:0]   r_out_div;
    logic [dtc_pkg::TIM_W-1:0]   r_out_cnt;
    logic                        r_out_irq;

    logic [dtc_pkg::CHUNK_W-1:0] chunk;
    logic [dtc_pkg::SYS_W-1:0]   sys_next;
    logic [3:0]                  tap;
    logic                        tick;

    always_comb begin
        chunk    = (r_remain >= dtc_pkg::CYC_W'(dtc_pkg::CHUNK_MAX)) ?
                   dtc_pkg::CHUNK_MAX : r_remain[dtc_pkg::CHUNK_W-1:0];
        sys_next = r_sys + dtc_pkg::SYS_W'(chunk);
        tap      = dtc_pkg::tap_index(r_ctrl[1:0]);
        // falling edge of the selected tap across this chunk
        tick     = r_ctrl[dtc_pkg::CTRL_ENABLE_BIT] && r_sys[tap] && !sys_next[tap];
    end

    // r_remain is already zero whenever a new item is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys    <= '0;
            r_tim    <= '0;
            r_remain <= '0;
            r_irq    <= 1'b0;
        end else if (i_cmd.load) begin
            r_irq    <= 1'b0;
            case (i_mode)
                dtc_pkg::MODE_ADVANCE: r_remain <= i_cycles;
                dtc_pkg::MODE_WRITE:   r_tim    <= i_write_value;
                dtc_pkg::MODE_CLEAR:   r_sys    <= '0;
                default:               r_remain <= '0;
            endcase
        end else if (i_cmd.step) begin
            r_sys    <= sys_next;
            r_remain <= r_remain - dtc_pkg::CYC_W'(chunk);
            if (tick) begin
                if (r_tim == '1) begin
                    r_tim <= r_reload;
                    r_irq <= 1'b1;
                end else begin
                    r_tim <= r_tim + dtc_pkg::TIM_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '0;
            r_reload <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == dtc_pkg::REG_TIMER_CONTROL) begin
                r_ctrl <= i_cfg_data[dtc_pkg::CTRL_W-1:0];
            end else if (i_cfg_index == dtc_pkg::REG_RELOAD_VALUE) begin
                r_reload <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_div <= r_sys[dtc_pkg::SYS_W-1 -: dtc_pkg::TIM_W];
            r_out_cnt <= r_tim;
            r_out_irq <= r_irq;
        end
    end

    assign o_sts.remain_zero = (r_remain == '0);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_divider         = r_out_div;
    assign o_counter         = r_out_cnt;
    assign o_irq             = r_out_irq;

`ifndef SYNTHESIS
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({i_cmd.load, i_cmd.step, i_cmd.emit}) <= 1)
        else $error("datapath commands overlap");

    a_remain_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && (r_remain != '0) |=> r_remain < $past(r_remain))
        else $error("cycle count did not decrease on a step");

    a_irq_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && r_irq |=> r_irq)
        else $error("interrupt flag lost within an advance");

    a_emit_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_remain == '0) && (!r_out_valid || i_out_ready))
        else $error("result emitted before the item finished or over a pending beat");
`endif

endmodule

@@ hdl/divider_timer_counter_core.sv @@
// Top level of the divider/timer counter block.
`timescale 1ns / 1ps
//
// Input stream (s side): one beat per item. tuser carries the mode (advance,
// write timer counter, clear system counter); tdata carries cycles and the
// new counter value. Output stream (m side): one beat per item with the
// divider byte, the timer counter and the overflow flag.
// Config channel: index 0 is timer control, index 1 the reload value; it is
// always ready. Writes must go in only while no item is in flight; the block itself does not enforce this.
// An advance item is accepted, then steps the system counter in chunks until
// its cycles are used up, and its result is then moved into the output
// register; write, clear, unused-mode and zero-cycle items take no chunk
// step. The chunk loop advances the system counter by at most four per clock
// in a single adder and tap-edge check.
// One item is processed at a time; the next is accepted once the result has
// been moved into the output register.
// If the receiver stalls, the result holds in the output register while the
// next item is accepted and run; that item then waits until the beat is taken.
// Reset (synchronous, active low) clears both counters, both config
// registers and any pending result.
//

module divider_timer_counter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] cycles, [15:8] write_value
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] divider, [15:8] counter, [16] interrupt_request
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [dtc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dtc_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    dtc_pkg::t_cmd cmd;
    dtc_pkg::t_sts sts;
    logic [dtc_pkg::TIM_W-1:0] divider;
    logic [dtc_pkg::TIM_W-1:0] counter;
    logic                      irq;

    assign o_cfg_ready = 1'b1;

    dtc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dtc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_s_tuser),
        .i_cycles      (i_s_tdata[7:0]),
        .i_write_value (i_s_tdata[15:8]),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_divider     (divider),
        .o_counter     (counter),
        .o_irq         (irq)
    );

    assign o_m_tdata = {7'd0, irq, counter, divider};

endmodule
